>>> rtl/core/lkvc_pkg.sv
// Shared types, widths and helper functions of the LRU key-value cache.
package lkvc_pkg;

    // Number of slots in the store.
    localparam int ENTRIES  = 4;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W   = SLOT_W;
    localparam int COUNT_W  = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 3;
    localparam int CMP_W    = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic lookup;
        logic update;
    } t_ctrl;

    // A capacity of zero behaves as one, anything above the slot count as the slot count.
    function automatic logic [CMP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (cap == '0) begin
            c = CMP_W'(1);
        end
        if (c > CMP_W'(ENTRIES)) begin
            c = CMP_W'(ENTRIES);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/lkvc_ctrl.sv
// Controller state machine that sequences lookup and update of each item.
module lkvc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output lkvc_pkg::t_ctrl o_ctrl
);
    import lkvc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept        = i_start && !r_busy;
    assign o_busy        = r_busy;
    assign o_ctrl.latch  = accept;
    assign o_ctrl.lookup = (r_state == S_LOOKUP);
    assign o_ctrl.update = (r_state == S_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOKUP;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOKUP: begin
                    r_state <= S_UPDATE;
                    r_busy  <= 1'b0;
                end
                S_UPDATE: begin
                    if (accept) begin
                        r_state <= S_LOOKUP;
                        r_busy  <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/lkvc_datapath.sv
// Datapath: key match, recency ranks, slot selection, stores and result registers.
module lkvc_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lkvc_pkg::t_ctrl                       i_ctrl,
    input  logic                                  i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]            i_cfg_data,
    input  logic                                  i_command,
    input  logic signed [lkvc_pkg::DATA_W-1:0]    i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]    i_value,
    output logic                                  o_valid,
    output logic                                  o_found,
    output logic signed [lkvc_pkg::DATA_W-1:0]    o_read_value
);
    import lkvc_pkg::*;

    // Item held for the duration of its work.
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_val;

    // Stores and replacement state.
    logic [DATA_W-1:0]  r_keys   [ENTRIES];
    logic [DATA_W-1:0]  r_values [ENTRIES];
    logic               r_valid  [ENTRIES];
    logic [RANK_W-1:0]  r_rank   [ENTRIES];
    logic [COUNT_W-1:0] r_count;
    logic [CAP_W-1:0]   r_capacity;

    // Lookup results.
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic              r_evict;
    logic [SLOT_W-1:0] r_victim;
    logic [DATA_W-1:0] r_rd_value;

    // Result registers.
    logic              r_out_valid;
    logic              r_found;
    logic [DATA_W-1:0] r_read_value;

    logic              match_any;
    logic [SLOT_W-1:0] match_slot;
    logic              full;
    logic [SLOT_W-1:0] victim;
    logic [SLOT_W-1:0] free_slot;

    always_comb begin
        match_any  = 1'b0;
        match_slot = '0;
        victim     = '0;
        free_slot  = '0;
        full       = (CMP_W'(r_count) >= eff_capacity(r_capacity));
        // Lowest-numbered slot wins in each search.
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                match_any  = 1'b1;
                match_slot = SLOT_W'(i);
            end
        end
        // Valid ranks are always 0 .. count-1, so the oldest holds count-1.
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_rank[i] == RANK_W'(r_count - COUNT_W'(1)))) begin
                victim = SLOT_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i] || (full && (victim == SLOT_W'(i)))) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // Payload registers and stores.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_ctrl.lookup) begin
            r_slot     <= match_any ? match_slot : free_slot;
            r_victim   <= victim;
            r_rd_value <= r_values[match_slot];
        end
        if (i_ctrl.update) begin
            if (r_cmd == CMD_PUT) begin
                r_values[r_slot] <= r_val;
                if (!r_hit) begin
                    r_keys[r_slot] <= r_key;
                end
            end
            r_found      <= r_hit;
            r_read_value <= (r_hit && (r_cmd == CMD_GET)) ? r_rd_value : '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_hit       <= 1'b0;
            r_evict     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctrl.update;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_ctrl.lookup) begin
                r_hit   <= match_any;
                r_evict <= !match_any && full;
            end
            if (i_ctrl.update) begin
                if (r_hit) begin
                    // Promote: entries more recent than the hit age by one.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (r_rank[i] < r_rank[r_slot])) begin
                            r_rank[i] <= r_rank[i] + RANK_W'(1);
                        end
                    end
                    r_rank[r_slot] <= '0;
                end else if (r_cmd == CMD_PUT) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && !(r_evict && (r_victim == SLOT_W'(i)))) begin
                            r_rank[i] <= r_rank[i] + RANK_W'(1);
                        end
                    end
                    // When the victim's own slot takes the new pair it simply stays valid.
                    if (r_evict && (r_victim != r_slot)) begin
                        r_valid[r_victim] <= 1'b0;
                    end
                    r_valid[r_slot] <= 1'b1;
                    r_rank[r_slot]  <= '0;
                    if (!r_evict) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;

endmodule

>>> rtl/core/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: controller plus datapath.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  --------------------------------
//  request   in         start, busy          i_command, i_key, i_value
//  result    out        o_valid (strobe)     o_found, o_read_value
//  config    in         i_cfg_we             i_cfg_data (capacity)
//
// An item is accepted at a clock edge where start is high and busy is low. It
// then takes a lookup cycle (key compare, hit, victim and free slot) with busy
// high and an update cycle (stores and ranks) in which the next item can be
// taken. o_valid is high for one cycle, registered at the end of the update
// cycle. Reset is synchronous: valid bits, ranks and count clear and capacity
// returns to four.
module lru_key_value_cache_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_command,
    input  logic signed [lkvc_pkg::DATA_W-1:0]    i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]    i_value,
    input  logic                                  i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic                                  o_found,
    output logic signed [lkvc_pkg::DATA_W-1:0]    o_read_value
);
    import lkvc_pkg::*;

    // Command bundle from the sequencer into the datapath.
    t_ctrl ctrl;

    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    // The datapath holds the key and value stores, the recency ranks and
    // the result registers, moved only by the controller; capacity by i_cfg_we.
    lkvc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

endmodule

>>> rtl/core/lkvc_checker.sv
// Port-level checker for the LRU key-value cache core and its bind.
module lkvc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic                               o_found,
    input logic [lkvc_pkg::DATA_W-1:0]        o_read_value
);
    import lkvc_pkg::*;

    // An accepted item makes the block busy for its lookup cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // Busy covers the lookup cycle only and then drops.
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // Every lookup leads to a result strobe, which follows its update cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> ##1 o_valid)
        else $error("result strobe missing after lookup");

    // A result strobe is never followed at once by another.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe on consecutive cycles");

    // A miss never returns data.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_read_value == '0))
        else $error("non-zero read value on a miss");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_read_value (o_read_value)
);
